// ----- rtl/mos_pkg.sv -----
// ----------------------------------------------------------------------------
// mos_pkg
// shared types, codes and sizes of the minimum-overlap shift search
// ----------------------------------------------------------------------------
package mos_pkg;

    localparam int KEYS_DEF    = 88;  // default vector length
    localparam int OP_W        = 2;   // op field width
    localparam int KEY_W       = 7;   // key_index field width
    localparam int SHIFT_W     = 8;   // transpose width, two's complement
    localparam int LANE_W      = 16;  // bits counted per first-stage lane
    localparam int IN_TDATA_W  = 8;   // key_index padded to bytes
    localparam int IN_TUSER_W  = 2;   // op
    localparam int OUT_TDATA_W = 16;  // transpose, locked, padded to bytes

    typedef enum logic [OP_W-1:0] {
        OP_TOGGLE_A = 2'd0,
        OP_TOGGLE_B = 2'd1,
        OP_OPTIMISE = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOWN,
        ST_UP,
        ST_DRAIN,
        ST_COMMIT,
        ST_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic toggle_a;    // flip one pattern mark
        logic toggle_b;    // flip one blocked mark
        logic clear;       // empty both vectors, drop lock and shift
        logic start;       // load work vector with pattern, shift 0
        logic eval;        // count overlap of work vector this cycle
        logic shift_dn;    // move work vector one place down
        logic restart_up;  // reload work vector with pattern one place up
        logic shift_up;    // move work vector one place up
        logic commit;      // apply best shift and lock
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic a_empty;     // no pattern mark set
        logic a_top;       // pattern mark set at the top position
        logic locked;      // edits blocked
        logic w_low;       // work vector has its lowest bit set
        logic w_top;       // work vector has its top bit set
    } t_dp_stat;

endpackage

// ----- rtl/mos_dp.sv -----
// ----------------------------------------------------------------------------
// mos_dp
// mark vectors, shifted work vector, two-stage overlap count and best pick
// ----------------------------------------------------------------------------
module mos_dp #(
    parameter int KEYS = mos_pkg::KEYS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mos_pkg::t_dp_cmd                  i_cmd,
    input  logic [mos_pkg::KEY_W-1:0]         i_key_pos,
    output mos_pkg::t_dp_stat                 o_stat,
    output logic signed [mos_pkg::SHIFT_W-1:0] o_transpose,
    output logic                              o_locked
);

    localparam int LANES = (KEYS + mos_pkg::LANE_W - 1) / mos_pkg::LANE_W;
    localparam int PADW  = LANES * mos_pkg::LANE_W;
    localparam int CW    = $clog2(KEYS + 1);
    localparam int LCW   = $clog2(mos_pkg::LANE_W + 1);
    localparam int KIW   = mos_pkg::KEY_W + 1;
    localparam int SW    = mos_pkg::SHIFT_W;

    function automatic logic [SW-1:0] f_abs(input logic signed [SW-1:0] v);
        return v[SW-1] ? SW'(-v) : SW'(v);
    endfunction

    logic [KEYS-1:0]        r_a;
    logic [KEYS-1:0]        r_b;
    logic signed [SW-1:0]   r_best_shift;
    logic                   r_locked;
    logic [KEYS-1:0]        r_w;
    logic signed [SW-1:0]   r_s;
    logic                   r_p_valid;
    logic [LCW-1:0]         r_p_cnt [LANES];
    logic signed [SW-1:0]   r_p_s;
    logic [KEYS-1:0]        r_p_vec;
    logic                   r_have;
    logic [CW-1:0]          r_cand_ov;
    logic signed [SW-1:0]   r_cand_s;
    logic [KEYS-1:0]        r_cand_vec;

    logic [KEYS-1:0]        w_mask;
    logic [PADW-1:0]        w_and_pad;
    logic [LCW-1:0]         w_lane_cnt [LANES];
    logic [CW-1:0]          w_total;
    logic [SW-1:0]          w_p_abs;
    logic [SW-1:0]          w_c_abs;
    logic                   w_better;

    // one-hot of the key; an index beyond the vector selects nothing
    always_comb begin
        for (int i = 0; i < KEYS; i++) begin
            w_mask[i] = ({1'b0, i_key_pos} == KIW'(i));
        end
    end

    // first stage: per-lane popcount of work AND blocked
    assign w_and_pad = PADW'(r_w & r_b);

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_lane_cnt[l] = '0;
            for (int j = 0; j < mos_pkg::LANE_W; j++) begin
                w_lane_cnt[l] = w_lane_cnt[l] + LCW'(w_and_pad[l*mos_pkg::LANE_W + j]);
            end
        end
    end

    // second stage: lane sum and candidate compare
    always_comb begin
        w_total = '0;
        for (int l = 0; l < LANES; l++) begin
            w_total = w_total + CW'(r_p_cnt[l]);
        end
    end

    assign w_p_abs  = f_abs(r_p_s);
    assign w_c_abs  = f_abs(r_cand_s);
    assign w_better = !r_have || (w_total < r_cand_ov) ||
                      ((w_total == r_cand_ov) &&
                       ((w_p_abs < w_c_abs) || ((w_p_abs == w_c_abs) && (r_p_s < r_cand_s))));

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a          <= '0;
            r_b          <= '0;
            r_best_shift <= '0;
            r_locked     <= 1'b0;
            r_p_valid    <= 1'b0;
        end else begin
            r_p_valid <= i_cmd.eval;
            if (i_cmd.clear) begin
                r_a          <= '0;
                r_b          <= '0;
                r_best_shift <= '0;
                r_locked     <= 1'b0;
            end else if (i_cmd.commit) begin
                r_a          <= r_cand_vec;
                r_best_shift <= r_cand_s;
                r_locked     <= 1'b1;
            end else begin
                if (i_cmd.toggle_a && !r_locked) begin
                    r_a <= r_a ^ w_mask;
                end
                if (i_cmd.toggle_b && !r_locked) begin
                    r_b <= r_b ^ w_mask;
                end
            end
        end
    end

    // search datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_w    <= r_a;
            r_s    <= '0;
            r_have <= 1'b0;
        end else if (i_cmd.shift_dn) begin
            r_w <= r_w >> 1;
            r_s <= r_s - SW'(1);
        end else if (i_cmd.restart_up) begin
            r_w <= r_a << 1;
            r_s <= SW'(1);
        end else if (i_cmd.shift_up) begin
            r_w <= r_w << 1;
            r_s <= r_s + SW'(1);
        end
        if (i_cmd.eval) begin
            r_p_cnt <= w_lane_cnt;
            r_p_s   <= r_s;
            r_p_vec <= r_w;
        end
        if (r_p_valid && w_better) begin
            r_have     <= 1'b1;
            r_cand_ov  <= w_total;
            r_cand_s   <= r_p_s;
            r_cand_vec <= r_p_vec;
        end
    end

    assign o_stat.a_empty = ~|r_a;
    assign o_stat.a_top   = r_a[KEYS-1];
    assign o_stat.locked  = r_locked;
    assign o_stat.w_low   = r_w[0];
    assign o_stat.w_top   = r_w[KEYS-1];
    assign o_transpose    = r_best_shift;
    assign o_locked       = r_locked;

endmodule

// ----- rtl/mos_ctrl.sv -----
// ----------------------------------------------------------------------------
// mos_ctrl
// sequencer: request decode, downward and upward shift sweep, commit, response
// ----------------------------------------------------------------------------
module mos_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [mos_pkg::OP_W-1:0]   i_op,
    input  mos_pkg::t_dp_stat          i_stat,
    output mos_pkg::t_dp_cmd           o_cmd,
    input  logic                       i_out_free,
    output logic                       o_load_out
);

    mos_pkg::t_state r_state;
    mos_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mos_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_load_out = 1'b0;
        case (r_state)
            mos_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = mos_pkg::ST_RESP;
                    case (mos_pkg::t_op'(i_op))
                        mos_pkg::OP_TOGGLE_A: o_cmd.toggle_a = 1'b1;
                        mos_pkg::OP_TOGGLE_B: o_cmd.toggle_b = 1'b1;
                        mos_pkg::OP_CLEAR:    o_cmd.clear    = 1'b1;
                        mos_pkg::OP_OPTIMISE: begin
                            if (!i_stat.locked && !i_stat.a_empty) begin
                                o_cmd.start = 1'b1;
                                n_state     = mos_pkg::ST_DOWN;
                            end
                        end
                        default: n_state = mos_pkg::ST_RESP;
                    endcase
                end
            end
            mos_pkg::ST_DOWN: begin
                o_cmd.eval = 1'b1;
                if (i_stat.w_low) begin
                    if (i_stat.a_top) begin
                        n_state = mos_pkg::ST_DRAIN;
                    end else begin
                        o_cmd.restart_up = 1'b1;
                        n_state          = mos_pkg::ST_UP;
                    end
                end else begin
                    o_cmd.shift_dn = 1'b1;
                end
            end
            mos_pkg::ST_UP: begin
                o_cmd.eval = 1'b1;
                if (i_stat.w_top) begin
                    n_state = mos_pkg::ST_DRAIN;
                end else begin
                    o_cmd.shift_up = 1'b1;
                end
            end
            mos_pkg::ST_DRAIN: begin
                n_state = mos_pkg::ST_COMMIT;
            end
            mos_pkg::ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = mos_pkg::ST_RESP;
            end
            mos_pkg::ST_RESP: begin
                if (i_out_free) begin
                    o_load_out = 1'b1;
                    n_state    = mos_pkg::ST_IDLE;
                end
            end
            default: n_state = mos_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/min_overlap_shift_search.sv -----
// ----------------------------------------------------------------------------
// min_overlap_shift_search
// keeps a pattern and a blocked mark vector and moves the pattern to the shift
// with the least overlap on request
// ----------------------------------------------------------------------------
// Each request carries an op in tuser and a key position in tdata. Toggles flip
// one pattern or blocked mark (ignored while locked or for an index past the
// vector), clear empties everything and drops the lock, and optimise tries
// every shift that keeps the pattern inside the vector, takes the one with the
// least overlap (ties: smallest magnitude, then most negative), moves the
// pattern there and locks. Every request gives one response with the stored
// shift and the lock flag. Toggles, clear and an optimise that does nothing
// go straight to the response state. In a real optimise, with lo and hi the
// lowest and highest pattern marks, the work vector walks down from shift 0
// to -lo and then, unless hi is already the top, up from +1 to the top, one
// shift per cycle through a two-stage popcount (lane counts, then lane sum
// and best-candidate compare), followed by the drain, commit and response
// states. A request is taken only while the sequencer is idle; the response
// register lets the next request in while a response still waits on the
// master side.
// ----------------------------------------------------------------------------
module min_overlap_shift_search #(
    parameter int KEYS = mos_pkg::KEYS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request side
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [mos_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // [6:0] key_pos, [7] zero
    input  logic [mos_pkg::IN_TUSER_W-1:0]     i_s_tuser,   // [1:0] op
    // response side
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [mos_pkg::OUT_TDATA_W-1:0]    o_m_tdata    // [7:0] transpose, [8] locked, rest zero
);

    localparam int SW = mos_pkg::SHIFT_W;

    mos_pkg::t_dp_cmd          w_cmd;
    mos_pkg::t_dp_stat         w_stat;
    logic signed [SW-1:0]      w_transpose;
    logic                      w_locked;
    logic                      w_out_free;
    logic                      w_load_out;

    // response register
    logic                      r_out_valid;
    logic [SW-1:0]             r_out_transpose;
    logic                      r_out_locked;

    // slot is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || i_m_tready;

    mos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_op       (i_s_tuser[mos_pkg::OP_W-1:0]),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .i_out_free (w_out_free),
        .o_load_out (w_load_out)
    );

    mos_dp #(
        .KEYS (KEYS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_key_pos   (i_s_tdata[mos_pkg::KEY_W-1:0]),
        .o_stat      (w_stat),
        .o_transpose (w_transpose),
        .o_locked    (w_locked)
    );

    // valid flag of the response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // response payload, captured after the request has been applied
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_transpose <= SW'(w_transpose);
            r_out_locked    <= w_locked;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = mos_pkg::OUT_TDATA_W'({r_out_locked, r_out_transpose});

    // one request at a time: after a request the sequencer is busy
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while previous one still in progress");

    // an unlocked response always reports a zero shift
    a_shift_needs_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[SW] || (o_m_tdata[SW-1:0] == '0)))
        else $error("nonzero shift reported without lock");

    // the lock only drops on an accepted clear request
    a_unlock_by_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_locked) |->
            $past(i_s_tvalid && o_s_tready && (i_s_tuser == mos_pkg::OP_CLEAR)))
        else $error("lock released without clear");

endmodule
